// ===== rtl/shutdown_fault_supervisor_macros.svh =====
// assertion macros for the shutdown fault supervisor
// used by the rtl modules that carry concurrent assertions
`ifndef SHUTDOWN_FAULT_SUPERVISOR_MACROS_SVH
`define SHUTDOWN_FAULT_SUPERVISOR_MACROS_SVH

// same-cycle implication
`define SFS_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define SFS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/sfs_pkg.sv =====
// shared types and constants for the shutdown fault supervisor
// no dependencies
`default_nettype none

package sfs_pkg;

    localparam int TimeWidth  = 32;
    localparam int DelayWidth = 16;
    localparam int PaddrWidth = 5;
    localparam int PdataWidth = 32;
    localparam int QueueDepth = 2;
    localparam int QueuePtrWidth = $clog2(QueueDepth);
    localparam int QueueCntWidth = $clog2(QueueDepth + 1);

    localparam logic [DelayWidth-1:0] AssertDelayReset   = 16'd200;
    localparam logic [DelayWidth-1:0] DeassertDelayReset = 16'd1000;
    localparam logic [DelayWidth-1:0] StartDelayReset    = 16'd100;
    localparam logic [DelayWidth-1:0] ToleranceReset     = 16'd250;
    localparam logic [DelayWidth-1:0] SegPeriodReset     = 16'd50;
    localparam logic [DelayWidth-1:0] McuPeriodReset     = 16'd200;
    localparam logic                  AllowCancelReset   = 1'b1;

    typedef enum logic [2:0] {
        REG_ASSERT_DELAY   = 3'd0,
        REG_DEASSERT_DELAY = 3'd1,
        REG_START_DELAY    = 3'd2,
        REG_TOLERANCE      = 3'd3,
        REG_SEG_PERIOD     = 3'd4,
        REG_MCU_PERIOD     = 3'd5,
        REG_ALLOW_CANCEL   = 3'd6
    } reg_index_t;

    typedef struct packed {
        logic [DelayWidth-1:0] assert_delay_ms;
        logic [DelayWidth-1:0] deassert_delay_ms;
        logic [DelayWidth-1:0] start_delay_ms;
        logic [DelayWidth-1:0] schedule_tolerance_ms;
        logic [DelayWidth-1:0] segment_period_ms;
        logic [DelayWidth-1:0] mcu_period_ms;
        logic                  allow_cancel;
    } cfg_t;

    // classified tick handed from front to back
    typedef struct packed {
        logic [TimeWidth-1:0] now_ms;
        logic                 deadline_overrun;
        logic                 bad_can;
        logic                 segment_fault;
        logic                 overcurrent;
    } entry_t;

    typedef struct packed {
        logic shutdown_ok;
        logic deadline_overrun;
        logic bad_can;
        logic segment_fault;
        logic overcurrent;
        logic request_pending;
    } result_t;

endpackage

`default_nettype wire

// ===== rtl/sfs_if.sv =====
// valid/ready channel interfaces for supervision ticks and results
// no dependencies
`default_nettype none

interface sfs_tick_if;
    logic        valid;
    logic        ready;
    logic [31:0] now_ms;
    logic [31:0] segment_task_time;
    logic [31:0] mcu_task_time;
    logic        can_online;
    logic        overcurrent_neg_pin;
    logic        overcurrent_pos_pin;
    logic        any_segment_stale;
    logic        any_segment_fault;

    modport source (
        output valid, now_ms, segment_task_time, mcu_task_time, can_online,
               overcurrent_neg_pin, overcurrent_pos_pin, any_segment_stale,
               any_segment_fault,
        input  ready
    );
    modport sink (
        input  valid, now_ms, segment_task_time, mcu_task_time, can_online,
               overcurrent_neg_pin, overcurrent_pos_pin, any_segment_stale,
               any_segment_fault,
        output ready
    );
endinterface

interface sfs_result_if;
    logic valid;
    logic ready;
    logic shutdown_ok;
    logic deadline_overrun;
    logic bad_can;
    logic segment_fault;
    logic overcurrent;
    logic request_pending;

    modport source (
        output valid, shutdown_ok, deadline_overrun, bad_can, segment_fault,
               overcurrent, request_pending,
        input  ready
    );
    modport sink (
        input  valid, shutdown_ok, deadline_overrun, bad_can, segment_fault,
               overcurrent, request_pending,
        output ready
    );
endinterface

`default_nettype wire

// ===== rtl/sfs_regs.sv =====
// apb configuration registers
// depends on sfs_pkg
`default_nettype none

module sfs_regs (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            psel,
    input  wire logic                            penable,
    input  wire logic                            pwrite,
    input  wire logic [sfs_pkg::PaddrWidth-1:0]  paddr,
    input  wire logic [sfs_pkg::PdataWidth-1:0]  pwdata,
    output logic      [sfs_pkg::PdataWidth-1:0]  prdata,
    output logic                                 pready,
    output sfs_pkg::cfg_t                        cfg
);

    sfs_pkg::cfg_t      cfg_reg;
    sfs_pkg::cfg_t      cfg_next;
    sfs_pkg::reg_index_t index;
    logic               wr_en;

    assign index  = sfs_pkg::reg_index_t'(paddr[sfs_pkg::PaddrWidth-1:2]);
    assign wr_en  = psel && penable && pwrite;
    assign pready = 1'b1;
    assign cfg    = cfg_reg;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            unique case (index)
                sfs_pkg::REG_ASSERT_DELAY:
                    cfg_next.assert_delay_ms = pwdata[sfs_pkg::DelayWidth-1:0];
                sfs_pkg::REG_DEASSERT_DELAY:
                    cfg_next.deassert_delay_ms = pwdata[sfs_pkg::DelayWidth-1:0];
                sfs_pkg::REG_START_DELAY:
                    cfg_next.start_delay_ms = pwdata[sfs_pkg::DelayWidth-1:0];
                sfs_pkg::REG_TOLERANCE:
                    cfg_next.schedule_tolerance_ms = pwdata[sfs_pkg::DelayWidth-1:0];
                sfs_pkg::REG_SEG_PERIOD:
                    cfg_next.segment_period_ms = pwdata[sfs_pkg::DelayWidth-1:0];
                sfs_pkg::REG_MCU_PERIOD:
                    cfg_next.mcu_period_ms = pwdata[sfs_pkg::DelayWidth-1:0];
                sfs_pkg::REG_ALLOW_CANCEL:
                    cfg_next.allow_cancel = pwdata[0];
                default:
                    cfg_next = cfg_reg;
            endcase
        end
    end

    always_comb
    begin
        unique case (index)
            sfs_pkg::REG_ASSERT_DELAY:   prdata = {16'd0, cfg_reg.assert_delay_ms};
            sfs_pkg::REG_DEASSERT_DELAY: prdata = {16'd0, cfg_reg.deassert_delay_ms};
            sfs_pkg::REG_START_DELAY:    prdata = {16'd0, cfg_reg.start_delay_ms};
            sfs_pkg::REG_TOLERANCE:      prdata = {16'd0, cfg_reg.schedule_tolerance_ms};
            sfs_pkg::REG_SEG_PERIOD:     prdata = {16'd0, cfg_reg.segment_period_ms};
            sfs_pkg::REG_MCU_PERIOD:     prdata = {16'd0, cfg_reg.mcu_period_ms};
            sfs_pkg::REG_ALLOW_CANCEL:   prdata = {31'd0, cfg_reg.allow_cancel};
            default:                     prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.assert_delay_ms       <= sfs_pkg::AssertDelayReset;
            cfg_reg.deassert_delay_ms     <= sfs_pkg::DeassertDelayReset;
            cfg_reg.start_delay_ms        <= sfs_pkg::StartDelayReset;
            cfg_reg.schedule_tolerance_ms <= sfs_pkg::ToleranceReset;
            cfg_reg.segment_period_ms     <= sfs_pkg::SegPeriodReset;
            cfg_reg.mcu_period_ms         <= sfs_pkg::McuPeriodReset;
            cfg_reg.allow_cancel          <= sfs_pkg::AllowCancelReset;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/sfs_front.sv =====
// front end: accepts ticks and forms the fault flags
// depends on sfs_pkg and sfs_if
`default_nettype none

module sfs_front (
    sfs_tick_if.sink             tick,
    input  wire sfs_pkg::cfg_t   cfg,
    input  wire logic            queue_full,
    output logic                 push,
    output sfs_pkg::entry_t      entry
);

    logic [sfs_pkg::TimeWidth-1:0] seg_age;
    logic [sfs_pkg::TimeWidth-1:0] mcu_age;
    logic [sfs_pkg::TimeWidth-1:0] tolerance;

    assign tick.ready = !queue_full;
    assign push       = tick.valid && !queue_full;

    // age against the nominal schedule: now - (task_time - period)
    assign seg_age   = tick.now_ms - tick.segment_task_time + {16'd0, cfg.segment_period_ms};
    assign mcu_age   = tick.now_ms - tick.mcu_task_time + {16'd0, cfg.mcu_period_ms};
    assign tolerance = {16'd0, cfg.schedule_tolerance_ms};

    always_comb
    begin
        entry.now_ms           = tick.now_ms;
        entry.deadline_overrun = (seg_age >= tolerance) || (mcu_age >= tolerance)
                                 || tick.any_segment_stale;
        entry.bad_can          = !tick.can_online;
        entry.segment_fault    = tick.any_segment_fault;
        entry.overcurrent      = !tick.overcurrent_neg_pin || !tick.overcurrent_pos_pin;
    end

endmodule

`default_nettype wire

// ===== rtl/sfs_queue.sv =====
// two-entry queue between front and back
// depends on sfs_pkg
`default_nettype none

module sfs_queue (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            push,
    input  wire sfs_pkg::entry_t entry_in,
    input  wire logic            pop,
    output logic                 full,
    output logic                 head_valid,
    output sfs_pkg::entry_t      head
);

    sfs_pkg::entry_t                        slot_reg [sfs_pkg::QueueDepth];
    logic [sfs_pkg::QueuePtrWidth-1:0]      wr_ptr_reg;
    logic [sfs_pkg::QueuePtrWidth-1:0]      wr_ptr_next;
    logic [sfs_pkg::QueuePtrWidth-1:0]      rd_ptr_reg;
    logic [sfs_pkg::QueuePtrWidth-1:0]      rd_ptr_next;
    logic [sfs_pkg::QueueCntWidth-1:0]      count_reg;
    logic [sfs_pkg::QueueCntWidth-1:0]      count_next;

    assign full       = (count_reg == sfs_pkg::QueueCntWidth'(sfs_pkg::QueueDepth));
    assign head_valid = (count_reg != '0);
    assign head       = slot_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == sfs_pkg::QueuePtrWidth'(sfs_pkg::QueueDepth - 1))
                          ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == sfs_pkg::QueuePtrWidth'(sfs_pkg::QueueDepth - 1))
                          ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= entry_in;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/sfs_back.sv =====
// back end: shutdown sequencer and result register
// depends on sfs_pkg, sfs_if and the assertion macros
`default_nettype none
`include "shutdown_fault_supervisor_macros.svh"

module sfs_back (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire sfs_pkg::cfg_t   cfg,
    input  wire logic            head_valid,
    input  wire sfs_pkg::entry_t head,
    output logic                 pop,
    sfs_result_if.source         result
);

    localparam int TW = sfs_pkg::TimeWidth;

    logic          started_reg;
    logic          request_valid_reg;
    logic          request_valid_next;
    logic [TW-1:0] request_time_reg;
    logic [TW-1:0] request_time_next;
    logic          shutdown_valid_reg;
    logic          shutdown_valid_next;
    logic          cleared_valid_reg;
    logic          cleared_valid_next;
    logic [TW-1:0] cleared_time_reg;
    logic [TW-1:0] cleared_time_next;
    logic          out_valid_reg;
    logic          out_valid_next;
    sfs_pkg::result_t result_reg;
    sfs_pkg::result_t result_next;

    logic          fault;
    logic          sv0;
    logic          cv0;
    logic [TW-1:0] ct0;
    logic          open_req;
    logic          rv1;
    logic          req_elapsed;
    logic          assert_now;
    logic          sv1;
    logic          arm;
    logic          cv1;
    logic          clr_elapsed;
    logic          first_elapsed;
    logic          rel_now;
    logic [TW-1:0] assert_delay;
    logic [TW-1:0] deassert_delay;
    logic [TW-1:0] start_delay;

    assign assert_delay   = {16'd0, cfg.assert_delay_ms};
    assign deassert_delay = {16'd0, cfg.deassert_delay_ms};
    assign start_delay    = {16'd0, cfg.start_delay_ms};

    assign pop            = head_valid && (!out_valid_reg || result.ready);
    assign out_valid_next = pop || (out_valid_reg && !result.ready);

    // on the first tick the release timer sits at (deassert - start) already
    assign first_elapsed = (deassert_delay - start_delay) >= deassert_delay;

    always_comb
    begin
        fault = head.deadline_overrun || head.bad_can || head.segment_fault
                || head.overcurrent;
        sv0   = started_reg ? shutdown_valid_reg : 1'b1;
        cv0   = started_reg ? cleared_valid_reg : 1'b1;
        ct0   = started_reg ? cleared_time_reg
                            : head.now_ms + start_delay - deassert_delay;

        open_req          = fault && !request_valid_reg;
        rv1               = request_valid_reg;
        request_time_next = request_time_reg;
        if (open_req)
        begin
            rv1               = 1'b1;
            request_time_next = head.now_ms;
        end
        else if (!fault && !sv0 && cfg.allow_cancel)
        begin
            rv1 = 1'b0;
        end
        req_elapsed = open_req ? (assert_delay == '0)
                               : ((head.now_ms - request_time_reg) >= assert_delay);
        assert_now  = (rv1 && req_elapsed) || head.overcurrent;
        sv1         = sv0 || assert_now;

        arm               = !cv0 && sv1 && !fault;
        cv1               = cv0;
        cleared_time_next = ct0;
        if (arm)
        begin
            cv1               = 1'b1;
            cleared_time_next = head.now_ms;
        end
        else if (cv0 && fault)
        begin
            cv1 = 1'b0;
        end
        if (arm)
        begin
            clr_elapsed = (deassert_delay == '0);
        end
        else if (started_reg)
        begin
            clr_elapsed = (head.now_ms - cleared_time_reg) >= deassert_delay;
        end
        else
        begin
            clr_elapsed = first_elapsed;
        end
        rel_now = !fault && cv1 && clr_elapsed;

        request_valid_next  = rel_now ? 1'b0 : rv1;
        cleared_valid_next  = rel_now ? 1'b0 : cv1;
        shutdown_valid_next = rel_now ? 1'b0 : sv1;

        result_next.shutdown_ok      = !shutdown_valid_next;
        result_next.deadline_overrun = head.deadline_overrun;
        result_next.bad_can          = head.bad_can;
        result_next.segment_fault    = head.segment_fault;
        result_next.overcurrent      = head.overcurrent;
        result_next.request_pending  = request_valid_next;
    end

    assign result.valid            = out_valid_reg;
    assign result.shutdown_ok      = result_reg.shutdown_ok;
    assign result.deadline_overrun = result_reg.deadline_overrun;
    assign result.bad_can          = result_reg.bad_can;
    assign result.segment_fault    = result_reg.segment_fault;
    assign result.overcurrent      = result_reg.overcurrent;
    assign result.request_pending  = result_reg.request_pending;

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            result_reg <= result_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            started_reg        <= 1'b0;
            request_valid_reg  <= 1'b0;
            request_time_reg   <= '0;
            shutdown_valid_reg <= 1'b1;
            cleared_valid_reg  <= 1'b1;
            cleared_time_reg   <= {16'd0, sfs_pkg::StartDelayReset}
                                  - {16'd0, sfs_pkg::DeassertDelayReset};
            out_valid_reg      <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            if (pop)
            begin
                started_reg        <= 1'b1;
                request_valid_reg  <= request_valid_next;
                request_time_reg   <= request_time_next;
                shutdown_valid_reg <= shutdown_valid_next;
                cleared_valid_reg  <= cleared_valid_next;
                cleared_time_reg   <= cleared_time_next;
            end
        end
    end

    `SFS_ASSERT_SAME(a_oc_asserts, clk, rst_n, pop && head.overcurrent,
                     !result_next.shutdown_ok, "overcurrent did not assert shutdown")
    `SFS_ASSERT_SAME(a_fault_clears_timer, clk, rst_n, pop && fault,
                     !cleared_valid_next, "release timer kept running during fault")
    `SFS_ASSERT_NEXT(a_started_sticks, clk, rst_n, started_reg,
                     started_reg, "started flag dropped")

endmodule

`default_nettype wire

// ===== rtl/shutdown_fault_supervisor.sv =====
// shutdown fault supervisor: one tick accepted per cycle while the queue is not full
// a tick enters the queue at acceptance and is sequenced into the result register
// once it is at the queue head and the result register is free; results can stall without
// stopping acceptance until the two-entry queue is full
// reset: shutdown asserted, release timer armed on the first tick, registers at defaults
`default_nettype none

module shutdown_fault_supervisor (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    sfs_tick_if.sink                             tick,
    sfs_result_if.source                         result,
    input  wire logic                            psel,
    input  wire logic                            penable,
    input  wire logic                            pwrite,
    input  wire logic [sfs_pkg::PaddrWidth-1:0]  paddr,
    input  wire logic [sfs_pkg::PdataWidth-1:0]  pwdata,
    output logic      [sfs_pkg::PdataWidth-1:0]  prdata,
    output logic                                 pready
);

    sfs_pkg::cfg_t   cfg;
    sfs_pkg::entry_t entry;
    sfs_pkg::entry_t head;
    logic            push;
    logic            pop;
    logic            queue_full;
    logic            head_valid;

    sfs_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    sfs_front u_front (
        .tick       (tick),
        .cfg        (cfg),
        .queue_full (queue_full),
        .push       (push),
        .entry      (entry)
    );

    sfs_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .entry_in   (entry),
        .pop        (pop),
        .full       (queue_full),
        .head_valid (head_valid),
        .head       (head)
    );

    sfs_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg),
        .head_valid (head_valid),
        .head       (head),
        .pop        (pop),
        .result     (result)
    );

endmodule

`default_nettype wire

// ===== verif/tb_shutdown_fault_supervisor.sv =====
`timescale 1ns / 1ps
// testbench for the shutdown fault supervisor: directed and random supervision ticks,
// every result checked against an in-bench model of the fault flags and shutdown sequencer
// depends on sfs_pkg, the sfs_if interfaces and the shutdown_fault_supervisor rtl

module tb_shutdown_fault_supervisor;

    localparam int WatchdogLimit = 4000;
    localparam int HoldOffCycles = 48;
    localparam int SettleCycles  = 6;
    localparam logic [4:0] Healthy = 5'b11100;

    // one supervision tick as offered on the input channel
    typedef struct {
        logic [31:0] now_ms;
        logic [31:0] segment_task_time;
        logic [31:0] mcu_task_time;
        logic        can_online;
        logic        oc_neg_n;
        logic        oc_pos_n;
        logic        stale;
        logic        seg_error;
    } tick_t;

    logic                           clk;
    logic                           rst_n;
    logic                           psel;
    logic                           penable;
    logic                           pwrite;
    logic [sfs_pkg::PaddrWidth-1:0] paddr;
    logic [sfs_pkg::PdataWidth-1:0] pwdata;
    logic [sfs_pkg::PdataWidth-1:0] prdata;
    logic                           pready;

    sfs_tick_if   tick_ch ();
    sfs_result_if result_ch ();

    shutdown_fault_supervisor u_top (
        .clk     (clk),
        .rst_n   (rst_n),
        .tick    (tick_ch),
        .result  (result_ch),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    // model state
    sfs_pkg::cfg_t    cfg;
    logic             powered_up;
    logic             req_open;
    logic [31:0]      req_since;
    logic             sd_active;
    logic             quiet_armed;
    logic [31:0]      quiet_since;

    sfs_pkg::result_t status_due[$];
    int               fail_count;
    int               src_idle_pct;
    int               sink_stall_pct;
    int               holdoff_requests;
    int               holdoff_served;
    int               step_max;
    logic [31:0]      now_clock;

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    function automatic logic aged(logic [31:0] now, logic [31:0] since, logic [15:0] span);
        logic [31:0] diff;
        diff = now - since;
        return diff >= {16'd0, span};
    endfunction

    function automatic sfs_pkg::result_t compute_status(tick_t t);
        sfs_pkg::result_t r;
        logic             overrun;
        logic             fault;
        if (!powered_up)
        begin
            powered_up  = 1'b1;
            sd_active   = 1'b1;
            quiet_armed = 1'b1;
            quiet_since = t.now_ms + {16'd0, cfg.start_delay_ms} - {16'd0, cfg.deassert_delay_ms};
        end
        overrun = aged(t.now_ms, t.segment_task_time - {16'd0, cfg.segment_period_ms},
                       cfg.schedule_tolerance_ms)
               || aged(t.now_ms, t.mcu_task_time - {16'd0, cfg.mcu_period_ms},
                       cfg.schedule_tolerance_ms)
               || t.stale;
        r.deadline_overrun = overrun;
        r.bad_can          = !t.can_online;
        r.segment_fault    = t.seg_error;
        r.overcurrent      = !t.oc_neg_n || !t.oc_pos_n;
        fault = overrun || r.bad_can || r.segment_fault || r.overcurrent;

        if (fault && !req_open)
        begin
            req_open  = 1'b1;
            req_since = t.now_ms;
        end
        else if (!fault && !sd_active && cfg.allow_cancel)
        begin
            req_open = 1'b0;
        end

        if (!sd_active && ((req_open && aged(t.now_ms, req_since, cfg.assert_delay_ms))
                           || r.overcurrent))
        begin
            sd_active = 1'b1;
        end

        if (!quiet_armed && sd_active && !fault)
        begin
            quiet_armed = 1'b1;
            quiet_since = t.now_ms;
        end
        else if (quiet_armed && fault)
        begin
            quiet_armed = 1'b0;
        end

        if (!fault && quiet_armed && aged(t.now_ms, quiet_since, cfg.deassert_delay_ms))
        begin
            req_open    = 1'b0;
            quiet_armed = 1'b0;
            sd_active   = 1'b0;
        end

        r.shutdown_ok     = !sd_active;
        r.request_pending = req_open;
        return r;
    endfunction

    function automatic tick_t tick_of(logic [31:0] now, logic [31:0] seg, logic [31:0] mcu,
                                      logic [4:0] flags);
        tick_t t;
        t.now_ms            = now;
        t.segment_task_time = seg;
        t.mcu_task_time     = mcu;
        {t.can_online, t.oc_neg_n, t.oc_pos_n, t.stale, t.seg_error} = flags;
        return t;
    endfunction

    function automatic tick_t healthy_at(logic [31:0] now);
        return tick_of(now, now, now, Healthy);
    endfunction

    // task age just under the overrun bound, or past it with the fault odds
    function automatic int task_age(int margin, int fault_pct);
        if ($urandom_range(99) < fault_pct)
        begin
            return (margin > 0 ? margin : 0) + int'($urandom_range(50));
        end
        return margin > 1 ? int'($urandom_range(margin - 1)) : 0;
    endfunction

    function automatic tick_t plant_tick(int fault_pct);
        tick_t t;
        now_clock = now_clock + $urandom_range(step_max);
        t.now_ms = now_clock;
        t.segment_task_time = now_clock - task_age(int'(cfg.schedule_tolerance_ms)
                                                   - int'(cfg.segment_period_ms), fault_pct);
        t.mcu_task_time = now_clock - task_age(int'(cfg.schedule_tolerance_ms)
                                               - int'(cfg.mcu_period_ms), fault_pct);
        t.can_online = ($urandom_range(99) >= fault_pct);
        t.oc_neg_n   = ($urandom_range(399) >= fault_pct);
        t.oc_pos_n   = ($urandom_range(399) >= fault_pct);
        t.stale      = ($urandom_range(199) < fault_pct);
        t.seg_error  = ($urandom_range(99) < fault_pct);
        return t;
    endfunction

    task automatic set_idling(input int mode);
        case (mode)
            0:
            begin
                src_idle_pct   = 0;
                sink_stall_pct = 0;
            end
            1:
            begin
                src_idle_pct   = 52;
                sink_stall_pct = 0;
            end
            2:
            begin
                src_idle_pct   = 0;
                sink_stall_pct = 52;
            end
            default:
            begin
                src_idle_pct   = 24;
                sink_stall_pct = 24;
            end
        endcase
    endtask

    task automatic send_tick(input tick_t t);
        while ($urandom_range(99) < src_idle_pct)
        begin
            tick_ch.valid <= 1'b0;
            @(posedge clk);
        end
        tick_ch.valid               <= 1'b1;
        tick_ch.now_ms              <= t.now_ms;
        tick_ch.segment_task_time   <= t.segment_task_time;
        tick_ch.mcu_task_time       <= t.mcu_task_time;
        tick_ch.can_online          <= t.can_online;
        tick_ch.overcurrent_neg_pin <= t.oc_neg_n;
        tick_ch.overcurrent_pos_pin <= t.oc_pos_n;
        tick_ch.any_segment_stale   <= t.stale;
        tick_ch.any_segment_fault   <= t.seg_error;
        do
        begin
            @(posedge clk);
        end
        while (!tick_ch.ready);
        status_due.push_back(compute_status(t));
    endtask

    task automatic settle();
        tick_ch.valid <= 1'b0;
        @(posedge clk);
        while (status_due.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (SettleCycles) @(posedge clk);
    endtask

    // leaves psel high so the next write can start its setup cycle at once
    task automatic write_reg(input sfs_pkg::reg_index_t idx, input logic [15:0] value);
        logic [31:0] noise;
        noise = $urandom;
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= {noise[31:16], value};
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        case (idx)
            sfs_pkg::REG_ASSERT_DELAY:   cfg.assert_delay_ms       = value;
            sfs_pkg::REG_DEASSERT_DELAY: cfg.deassert_delay_ms     = value;
            sfs_pkg::REG_START_DELAY:    cfg.start_delay_ms        = value;
            sfs_pkg::REG_TOLERANCE:      cfg.schedule_tolerance_ms = value;
            sfs_pkg::REG_SEG_PERIOD:     cfg.segment_period_ms     = value;
            sfs_pkg::REG_MCU_PERIOD:     cfg.mcu_period_ms         = value;
            sfs_pkg::REG_ALLOW_CANCEL:   cfg.allow_cancel          = value[0];
            default:                     ;
        endcase
    endtask

    task automatic apply_cfg(input logic [15:0] assert_ms, input logic [15:0] deassert_ms,
                             input logic [15:0] start_ms, input logic [15:0] tol_ms,
                             input logic [15:0] seg_ms, input logic [15:0] mcu_ms,
                             input logic cancel);
        logic [14:0] junk;
        junk = 15'($urandom);
        settle();
        write_reg(sfs_pkg::REG_ASSERT_DELAY, assert_ms);
        write_reg(sfs_pkg::REG_DEASSERT_DELAY, deassert_ms);
        write_reg(sfs_pkg::REG_START_DELAY, start_ms);
        write_reg(sfs_pkg::REG_TOLERANCE, tol_ms);
        write_reg(sfs_pkg::REG_SEG_PERIOD, seg_ms);
        write_reg(sfs_pkg::REG_MCU_PERIOD, mcu_ms);
        write_reg(sfs_pkg::REG_ALLOW_CANCEL, {junk, cancel});
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic run_ticks(input int count, input int fault_pct);
        int pct;
        pct = 0;
        for (int i = 0; i < count; i++)
        begin
            if (i % 40 == 0)
            begin
                set_idling((i / 40) % 4);
            end
            if (i % 20 == 0)
            begin
                pct = ($urandom_range(2) == 0) ? 0
                    : ($urandom_range(1) ? fault_pct : fault_pct / 4);
            end
            send_tick(plant_tick(pct));
        end
    endtask

    // first tick arms release with start delay above deassert delay
    task automatic test_start_release();
        int offs[5] = '{0, 700, 1499, 1500, 1600};
        apply_cfg(16'd200, 16'd1000, 16'd1500, 16'd250, 16'd50, 16'd200, 1'b1);
        set_idling(0);
        now_clock = 32'h0000_4000;
        foreach (offs[i])
        begin
            send_tick(healthy_at(now_clock + offs[i]));
        end
        now_clock = now_clock + 1600;
    endtask

    task automatic test_field_extremes();
        logic [31:0] t;
        t = now_clock;
        send_tick(tick_of(32'hFFFF_FFFF, 32'h0, 32'h0, Healthy));
        send_tick(tick_of(32'h0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, Healthy));
        send_tick(tick_of(32'h8000_0000, 32'h0, 32'hFFFF_FFFF, Healthy));
        send_tick(tick_of(t, t, t, 5'b01100));
        send_tick(tick_of(t + 5, t + 5, t + 5, 5'b10100));
        send_tick(tick_of(t + 10, t + 10, t + 10, 5'b11000));
        send_tick(tick_of(t + 15, t + 15, t + 15, 5'b11110));
        send_tick(tick_of(t + 20, t + 20, t + 20, 5'b11101));
        send_tick(tick_of(t + 25, t + 25, t + 25, 5'b00011));
        now_clock = t + 25;
    endtask

    // zero delays act at once; zero tolerance flags overrun on every tick
    task automatic test_zero_settings();
        logic [31:0] t;
        apply_cfg(16'd0, 16'd0, 16'd0, 16'hFFFF, 16'd0, 16'd0, 1'b1);
        t = now_clock + 100;
        send_tick(healthy_at(t));
        send_tick(tick_of(t + 1, t + 1, t + 1, 5'b11101));
        send_tick(healthy_at(t + 2));
        send_tick(tick_of(t + 3, t + 3, t + 3, 5'b11000));
        apply_cfg(16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 1'b1);
        send_tick(healthy_at(t + 4));
        send_tick(healthy_at(t + 5));
        now_clock = t + 5;
    endtask

    // request stays open after the fault clears and asserts on its delay
    task automatic test_no_cancel();
        logic [31:0] t;
        apply_cfg(16'd100, 16'd50, 16'd0, 16'd250, 16'd50, 16'd200, 1'b0);
        t = now_clock + 1000;
        send_tick(healthy_at(t));
        send_tick(healthy_at(t + 60));
        send_tick(tick_of(t + 100, t + 100, t + 100, 5'b11101));
        send_tick(healthy_at(t + 110));
        send_tick(healthy_at(t + 199));
        send_tick(healthy_at(t + 200));
        send_tick(healthy_at(t + 260));
        now_clock = t + 260;
    endtask

    task automatic test_random_defaults();
        apply_cfg(16'd200, 16'd1000, 16'd100, 16'd250, 16'd50, 16'd200, 1'b1);
        step_max = 100;
        run_ticks(380, 30);
    endtask

    task automatic test_random_short_delays();
        apply_cfg(16'd12, 16'd40, 16'd5, 16'd60, 16'd10, 16'd25, 1'b1);
        step_max = 8;
        run_ticks(350, 25);
    endtask

    task automatic test_random_no_cancel();
        apply_cfg(16'd20, 16'd30, 16'd0, 16'd40, 16'd5, 16'd15, 1'b0);
        step_max = 6;
        run_ticks(200, 20);
    endtask

    task automatic test_random_extremes();
        apply_cfg(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'd0, 16'd100, 1'b0);
        step_max = 20000;
        run_ticks(100, 20);
        apply_cfg(16'd0, 16'd0, 16'd0, 16'd0, 16'hFFFF, 16'hFFFF, 1'b1);
        step_max = 10;
        run_ticks(40, 10);
        apply_cfg(16'd0, 16'd0, 16'd0, 16'hFFFF, 16'd1, 16'd0, 1'b1);
        run_ticks(40, 20);
    endtask

    task automatic test_time_wrap();
        apply_cfg(16'd30, 16'd80, 16'd0, 16'd120, 16'd20, 16'd40, 1'b1);
        now_clock = 32'hFFFF_FC00;
        step_max = 40;
        run_ticks(150, 20);
    endtask

    task automatic test_random_noise();
        tick_t t;
        for (int i = 0; i < 120; i++)
        begin
            if (i % 40 == 0)
            begin
                set_idling((i / 40 + 1) % 4);
            end
            t.now_ms            = $urandom;
            t.segment_task_time = $urandom;
            t.mcu_task_time     = $urandom;
            t.can_online        = $urandom_range(1);
            t.oc_neg_n          = $urandom_range(1);
            t.oc_pos_n          = $urandom_range(1);
            t.stale             = $urandom_range(1);
            t.seg_error         = $urandom_range(1);
            send_tick(t);
        end
    endtask

    // result side holds off while ticks keep coming, filling the block
    task automatic test_backpressure();
        set_idling(0);
        step_max = 20;
        holdoff_requests = holdoff_requests + 1;
        for (int i = 0; i < 40; i++)
        begin
            send_tick(plant_tick(10));
        end
    endtask

    initial
    begin
        rst_n                       = 1'b0;
        psel                        = 1'b0;
        penable                     = 1'b0;
        pwrite                      = 1'b0;
        paddr                       = '0;
        pwdata                      = '0;
        tick_ch.valid               = 1'b0;
        tick_ch.now_ms              = '0;
        tick_ch.segment_task_time   = '0;
        tick_ch.mcu_task_time       = '0;
        tick_ch.can_online          = 1'b1;
        tick_ch.overcurrent_neg_pin = 1'b1;
        tick_ch.overcurrent_pos_pin = 1'b1;
        tick_ch.any_segment_stale   = 1'b0;
        tick_ch.any_segment_fault   = 1'b0;
        cfg.assert_delay_ms         = sfs_pkg::AssertDelayReset;
        cfg.deassert_delay_ms       = sfs_pkg::DeassertDelayReset;
        cfg.start_delay_ms          = sfs_pkg::StartDelayReset;
        cfg.schedule_tolerance_ms   = sfs_pkg::ToleranceReset;
        cfg.segment_period_ms       = sfs_pkg::SegPeriodReset;
        cfg.mcu_period_ms           = sfs_pkg::McuPeriodReset;
        cfg.allow_cancel            = sfs_pkg::AllowCancelReset;
        powered_up                  = 1'b0;
        req_open                    = 1'b0;
        req_since                   = '0;
        sd_active                   = 1'b1;
        quiet_armed                 = 1'b1;
        quiet_since                 = {16'd0, sfs_pkg::StartDelayReset}
                                      - {16'd0, sfs_pkg::DeassertDelayReset};
        fail_count                  = 0;
        holdoff_requests            = 0;
        step_max                    = 10;
        now_clock                   = '0;
        set_idling(0);
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_start_release();
        test_field_extremes();
        test_zero_settings();
        test_no_cancel();
        test_random_defaults();
        test_random_short_delays();
        test_random_no_cancel();
        test_backpressure();
        test_random_extremes();
        test_time_wrap();
        test_random_noise();
        settle();

        if (fail_count == 0)
        begin
            $display("PASS shutdown_fault_supervisor");
        end
        else
        begin
            $display("FAIL shutdown_fault_supervisor");
        end
        $finish;
    end

    // result side: check each transaction, then pick ready for the next cycle
    initial
    begin
        int               hold_left;
        sfs_pkg::result_t got;
        sfs_pkg::result_t want;
        hold_left       = 0;
        holdoff_served  = 0;
        result_ch.ready = 1'b0;
        forever
        begin
            @(posedge clk);
            if (rst_n && result_ch.valid && result_ch.ready)
            begin
                got.shutdown_ok      = result_ch.shutdown_ok;
                got.deadline_overrun = result_ch.deadline_overrun;
                got.bad_can          = result_ch.bad_can;
                got.segment_fault    = result_ch.segment_fault;
                got.overcurrent      = result_ch.overcurrent;
                got.request_pending  = result_ch.request_pending;
                if (status_due.size() == 0)
                begin
                    fail_count = fail_count + 1;
                    if (fail_count <= 10)
                    begin
                        $display("unexpected result transaction at %0t", $realtime);
                    end
                end
                else
                begin
                    want = status_due.pop_front();
                    if (got !== want)
                    begin
                        fail_count = fail_count + 1;
                        if (fail_count <= 10)
                        begin
                            // bits: ok ovr can seg oc req
                            $display("mismatch at %0t exp %b got %b",
                                     $realtime, want, got);
                        end
                    end
                end
            end
            if (holdoff_requests != holdoff_served)
            begin
                holdoff_served = holdoff_served + 1;
                hold_left = HoldOffCycles;
            end
            if (hold_left > 0)
            begin
                hold_left = hold_left - 1;
                result_ch.ready <= 1'b0;
            end
            else
            begin
                result_ch.ready <= ($urandom_range(99) >= sink_stall_pct);
            end
        end
    end

    initial
    begin : watchdog
        int quiet_cycles;
        quiet_cycles = 0;
        @(posedge rst_n);
        while (quiet_cycles < WatchdogLimit)
        begin
            @(posedge clk);
            if ((tick_ch.valid && tick_ch.ready) || (result_ch.valid && result_ch.ready))
            begin
                quiet_cycles = 0;
            end
            else
            begin
                quiet_cycles = quiet_cycles + 1;
            end
        end
        $display("FAIL shutdown_fault_supervisor");
        $finish;
    end

endmodule

// ===== files.f =====
+incdir+rtl
rtl/sfs_pkg.sv
rtl/sfs_if.sv
rtl/sfs_regs.sv
rtl/sfs_front.sv
rtl/sfs_queue.sv
rtl/sfs_back.sv
rtl/shutdown_fault_supervisor.sv
verif/tb_shutdown_fault_supervisor.sv
